// File: design/tfp_pkg.sv
// shared types, constants and defaults of the telecommand frame parser
package tfp_pkg;

  localparam int MAX_LEN_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] START_RESET = 8'd36;
  localparam logic [7:0] STOP_RESET  = 8'd35;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_STOP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_START   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } back_state_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic       we;
    logic       index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// File: design/tfp_if.sv
// stream interfaces for received bytes and frame results
interface tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_code;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic [4:0] payload_length;
  logic       last;

  modport source (output valid, output command_code, output payload_byte,
                  output byte_valid, output payload_length, output last, input ready);
  modport sink (input valid, input command_code, input payload_byte,
                input byte_valid, input payload_length, input last, output ready);
endinterface

// File: design/tfp_queue.sv
// small fifo of operations between the parser front and the emitter back
module tfp_queue
  import tfp_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/tfp_front.sv
// parser front: classifies received bytes and issues store and emit operations
module tfp_front
  import tfp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int OP_W    = 9 + CNT_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_wr_t         cfg,
  tfp_in_if.sink          in_ch,
  output logic            op_push,
  output logic [OP_W-1:0] op_data,
  input  logic            op_full
);

  logic [7:0]       start_r, stop_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             sign_r, sign_nxt;
  logic             dot_r, dot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             acc;
  logic [7:0]       b;
  op_kind_t         op_kind;
  logic [7:0]       op_byte;
  logic [CNT_W-1:0] op_cnt;
  logic             room;

  assign in_ch.ready = !op_full;
  assign acc         = in_ch.valid && !op_full;
  assign b           = in_ch.rx_byte;
  assign room        = (cnt_r < CNT_W'(MAX_LEN));
  assign op_data     = {op_kind, op_byte, op_cnt};

  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    sign_nxt  = sign_r;
    dot_nxt   = dot_r;
    cnt_nxt   = cnt_r;
    op_push   = 1'b0;
    op_kind   = OP_STORE;
    op_byte   = b;
    op_cnt    = cnt_r;
    if (acc) begin
      unique case (phase_r)
        PH_START: begin
          sign_nxt = 1'b0;
          dot_nxt  = 1'b0;
          cnt_nxt  = '0;
          if (b == start_r) begin
            phase_nxt = PH_START;
          end else begin
            code_nxt  = b;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (b == CH_PLUS || b == CH_MINUS || b == CH_DOT
              || (b >= CH_ZERO && b <= CH_NINE)) begin
            if ((b == CH_PLUS || b == CH_MINUS) && (sign_r || cnt_r != '0)) begin
              phase_nxt = PH_IDLE;
            end else if (b == CH_DOT && dot_r) begin
              phase_nxt = PH_IDLE;
            end else if (!room) begin
              phase_nxt = PH_IDLE;
            end else begin
              if (b == CH_PLUS || b == CH_MINUS) begin
                sign_nxt = 1'b1;
              end
              if (b == CH_DOT) begin
                dot_nxt = 1'b1;
              end
              op_push = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (b == start_r) begin
            sign_nxt  = 1'b0;
            dot_nxt   = 1'b0;
            cnt_nxt   = '0;
            phase_nxt = PH_START;
          end else if (b == stop_r) begin
            op_push   = 1'b1;
            op_kind   = OP_EMIT;
            op_byte   = code_r;
            sign_nxt  = 1'b0;
            dot_nxt   = 1'b0;
            cnt_nxt   = '0;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          sign_nxt  = 1'b0;
          dot_nxt   = 1'b0;
          cnt_nxt   = '0;
          phase_nxt = (b == start_r) ? PH_START : PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
      stop_r  <= STOP_RESET;
      phase_r <= PH_IDLE;
      code_r  <= '0;
      sign_r  <= 1'b0;
      dot_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg.we && cfg.index == CFG_START) begin
        start_r <= cfg.data;
      end
      if (cfg.we && cfg.index == CFG_STOP) begin
        stop_r <= cfg.data;
      end
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      sign_r  <= sign_nxt;
      dot_r   <= dot_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/tfp_back.sv
// emitter back: writes the payload memory and streams out completed frames
module tfp_back
  import tfp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int OP_W    = 9 + CNT_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  logic [OP_W-1:0] op_data,
  output logic            op_pop,
  tfp_out_if.source       out_ch
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [7:0]       mem [MAX_LEN];
  back_state_t      state_r, state_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [7:0]       rd_r;
  op_kind_t         op_kind;
  logic [7:0]       op_byte;
  logic [CNT_W-1:0] op_cnt;
  logic             is_last;
  logic             mem_we;

  assign op_kind = op_kind_t'(op_data[OP_W-1]);
  assign op_byte = op_data[OP_W-2:CNT_W];
  assign op_cnt  = op_data[CNT_W-1:0];
  assign is_last = (len_r == '0) || (k_r + 1'b1 == len_r);

  assign out_ch.valid          = (state_r == BK_SEND);
  assign out_ch.command_code   = code_r;
  assign out_ch.payload_byte   = (len_r == '0) ? 8'd0 : rd_r;
  assign out_ch.byte_valid     = (len_r != '0);
  assign out_ch.payload_length = 5'(len_r);
  assign out_ch.last           = is_last;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    op_pop    = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          if (op_kind == OP_STORE) begin
            mem_we = 1'b1;
          end else begin
            code_nxt  = op_byte;
            len_nxt   = op_cnt;
            k_nxt     = '0;
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: begin
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (out_ch.ready) begin
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = BK_READ;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      code_r  <= '0;
      len_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[op_cnt[IDX_W-1:0]] <= op_byte;
    end
    if (state_r == BK_READ) begin
      rd_r <= mem[k_r[IDX_W-1:0]];
    end
  end

endmodule

// File: design/telecommand_frame_parser_top.sv
// top level of the telecommand frame parser
//
//   channel  direction  content
//   in_ch    sink       rx_byte, one received byte per beat
//   out_ch   source     command_code, payload_byte, byte_valid, payload_length, last
//   cfg_*    write      start byte (index 0), stop byte (index 1)
//
// the front takes one byte per cycle while its two-entry operation queue has room
// each stored payload character and each stop byte that closes a frame costs one queue slot
// each result of a frame burst passes through a payload memory read, then the output register
// synchronous active-low reset clears parser phase, queue and emitter, no clearing pass
// the front keeps parsing bytes while the back waits on out_ch.ready, until the operation queue is full
module telecommand_frame_parser_top
  import tfp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  tfp_in_if.sink     in_ch,
  tfp_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int OP_W  = 9 + CNT_W;

  cfg_wr_t         cfg;
  logic            op_push;
  logic [OP_W-1:0] op_push_data;
  logic            op_full;
  logic            op_pop;
  logic [OP_W-1:0] op_pop_data;
  logic            op_valid;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  tfp_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .OP_W    (OP_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .op_push (op_push),
    .op_data (op_push_data),
    .op_full (op_full)
  );

  tfp_queue #(
    .W     (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_push_data),
    .full      (op_full),
    .pop       (op_pop),
    .pop_data  (op_pop_data),
    .not_empty (op_valid)
  );

  tfp_back #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .OP_W    (OP_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_data  (op_pop_data),
    .op_pop   (op_pop),
    .out_ch   (out_ch)
  );

endmodule

// File: dv/telecommand_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// testbench of the telecommand frame parser: directed and random byte streams against a parser model
module telecommand_frame_parser_top_tb;
  import tfp_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] command_code;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [4:0] payload_length;
    logic       last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  tfp_in_if  in_ch ();
  tfp_out_if out_ch ();

  telecommand_frame_parser_top #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // parser model state
  logic [7:0]    frame_open;
  logic [7:0]    frame_close;
  phase_t        rx_phase;
  logic [7:0]    rx_code;
  logic          rx_sign;
  logic          rx_dot;
  int            rx_count;
  logic [7:0]    rx_store [MAX_LEN];
  frame_result_t pending_results [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always #4 clk = ~clk;

  function automatic void clear_frame();
    rx_sign = 1'b0;
    rx_dot = 1'b0;
    rx_count = 0;
  endfunction

  function automatic void store_char(input logic [7:0] c);
    if (rx_count >= MAX_LEN) begin
      rx_phase = PH_IDLE;
    end else begin
      rx_store[rx_count] = c;
      rx_count++;
      rx_phase = PH_PAYLOAD;
    end
  endfunction

  function automatic void emit_frame();
    frame_result_t res;
    int k;
    res.command_code = rx_code;
    if (rx_count == 0) begin
      res.payload_byte = 8'h00;
      res.byte_valid = 1'b0;
      res.payload_length = 5'd0;
      res.last = 1'b1;
      pending_results.push_back(res);
    end else begin
      for (k = 0; k < rx_count; k++) begin
        res.payload_byte = rx_store[k];
        res.byte_valid = 1'b1;
        res.payload_length = 5'(rx_count);
        res.last = (k == rx_count - 1);
        pending_results.push_back(res);
      end
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (rx_phase)
      PH_START: begin
        clear_frame();
        if (b == frame_open) begin
          rx_phase = PH_START;
        end else begin
          rx_code = b;
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (b == CH_PLUS || b == CH_MINUS) begin
          if (!rx_sign && rx_count == 0) begin
            rx_sign = 1'b1;
            store_char(b);
          end else begin
            rx_phase = PH_IDLE;
          end
        end else if (b == CH_DOT) begin
          if (!rx_dot) begin
            rx_dot = 1'b1;
            store_char(b);
          end else begin
            rx_phase = PH_IDLE;
          end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          store_char(b);
        end else if (b == frame_open) begin
          clear_frame();
          rx_phase = PH_START;
        end else if (b == frame_close) begin
          emit_frame();
          clear_frame();
          rx_phase = PH_IDLE;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      default: begin
        clear_frame();
        rx_phase = (b == frame_open) ? PH_START : PH_IDLE;
      end
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: command_code %0h payload_byte %0h",
               out_ch.command_code, out_ch.payload_byte);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("command_code", want.command_code, out_ch.command_code);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
        check_field("payload_length", 8'(want.payload_length), 8'(out_ch.payload_length));
        check_field("last", 8'(want.last), 8'(out_ch.last));
      end
    end
  end

  // result side: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // called and returns at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_codes(input logic [7:0] open_code, input logic [7:0] close_code);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= open_code;
    @(posedge clk);
    frame_open = open_code;
    @(negedge clk);
    cfg_index <= CFG_STOP;
    cfg_wdata <= close_code;
    @(posedge clk);
    frame_close = close_code;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] random_frame_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_PLUS || c == CH_MINUS || c == CH_DOT ||
               (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  // mostly well-formed frames, some with a flaw; returns beats sent
  task automatic send_random_frame(output int beats);
    int len, dot_pos, flaw, k;
    logic [7:0] ch;
    len = ($urandom_range(0, 5) == 0) ? MAX_LEN : $urandom_range(0, MAX_LEN);
    flaw = $urandom_range(0, 11);
    if (flaw == 9) len = MAX_LEN + 1;
    dot_pos = ($urandom_range(0, 1) == 1 && len > 0) ? $urandom_range(0, len - 1) : -1;
    send_byte(frame_open);
    send_byte(($urandom_range(0, 9) == 0) ? frame_close : 8'($urandom_range(0, 255)));
    for (k = 0; k < len; k++) begin
      if (k == dot_pos) begin
        ch = CH_DOT;
      end else if (k == 0 && $urandom_range(0, 2) == 0) begin
        ch = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      end else begin
        ch = 8'(CH_ZERO + $urandom_range(0, 9));
      end
      if (k == len / 2) begin
        if (flaw == 10) ch = 8'($urandom_range(0, 255));
        if (flaw == 11) ch = $urandom_range(0, 1) ? CH_DOT : CH_MINUS;
      end
      send_byte(ch);
    end
    send_byte(frame_close);
    beats = len + 3;
  endtask

  task automatic run_random_phase(input int beats_wanted, input int idle_pct,
                                  input int stall_pct, input logic [7:0] open_code,
                                  input logic [7:0] close_code);
    int sent, beats, k;
    settle();
    write_frame_codes(open_code, close_code);
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    @(negedge clk);
    sent = 0;
    while (sent < beats_wanted) begin
      if ($urandom_range(0, 4) == 0) begin
        for (k = 0; k < $urandom_range(1, 4); k++) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_random_frame(beats);
        sent += beats;
      end
    end
  endtask

  task automatic test_empty_payload();
    send_byte(frame_open);
    send_byte(8'h00);
    send_byte(frame_close);
    // stop code taken as command id
    send_byte(frame_open);
    send_byte(frame_close);
    send_byte(frame_close);
  endtask

  task automatic test_signed_decimal();
    send_byte(frame_open);
    send_byte(8'hFF);
    send_byte(CH_MINUS);
    send_byte(CH_NINE);
    send_byte(CH_DOT);
    send_byte(CH_ZERO);
    send_byte(frame_close);
  endtask

  task automatic test_malformed_payload();
    send_byte(frame_open);
    send_byte(8'h01);
    send_byte(CH_ZERO);
    send_byte(CH_PLUS);
    send_byte(frame_open);
    send_byte(8'h02);
    send_byte(CH_DOT);
    send_byte(CH_DOT);
    send_byte(frame_close);
  endtask

  task automatic test_restart();
    send_byte(frame_open);
    send_byte(frame_open);
    send_byte(8'h07);
    send_byte(8'h35);
    send_byte(frame_open);
    send_byte(8'h08);
    send_byte(8'h34);
    send_byte(frame_close);
  endtask

  task automatic test_backpressure();
    int f, k;
    settle();
    @(posedge clk);
    hold_cycles = 200;
    @(negedge clk);
    for (f = 0; f < 4; f++) begin
      send_byte(frame_open);
      send_byte(8'(8'h40 + f));
      for (k = 0; k < 8; k++) send_byte(8'(CH_ZERO + k));
      send_byte(frame_close);
    end
  endtask

  task automatic test_codes_on_payload();
    settle();
    // start code equal to a digit: the digit check wins inside a payload
    write_frame_codes(8'h37, 8'h80);
    send_byte(8'h37);
    send_byte(8'h00);
    send_byte(8'h37);
    send_byte(8'h80);
    settle();
    // equal start and stop codes: the start check wins, frame never closes
    write_frame_codes(8'hC3, 8'hC3);
    send_byte(8'hC3);
    send_byte(8'h09);
    send_byte(CH_ZERO);
    send_byte(8'hC3);
    send_byte(8'hC3);
  endtask

  initial begin
    logic [7:0] open_code, close_code;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START;
    cfg_wdata = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    frame_open = START_RESET;
    frame_close = STOP_RESET;
    rx_phase = PH_IDLE;
    rx_code = 8'h00;
    clear_frame();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_payload();
    test_signed_decimal();
    test_malformed_payload();
    test_restart();
    test_backpressure();
    test_codes_on_payload();

    open_code = random_frame_code();
    do close_code = random_frame_code(); while (close_code == open_code);
    run_random_phase(75, 0, 0, 8'h00, 8'hFF);
    run_random_phase(75, 72, 0, 8'hFF, 8'h00);
    run_random_phase(75, 0, 72, open_code, close_code);
    run_random_phase(75, 30, 30, START_RESET, STOP_RESET);
    settle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
